>>> design/lcgrs_pkg.sv
// lcgrs_pkg: shared types and constants for the ranged random source
// item structs, command codes and generator constants
// no dependencies
package lcgrs_pkg;

   localparam logic [1:0] CMD_RAW    = 2'd0;
   localparam logic [1:0] CMD_RANGED = 2'd1;
   localparam logic [1:0] CMD_LOAD   = 2'd2;
   localparam logic [1:0] CMD_PEEK   = 2'd3;

   localparam logic [31:0] LCG_MUL = 32'd1664525;
   localparam logic [31:0] LCG_INC = 32'd1013904223;

   typedef struct packed {
      logic [1:0]         cmd;
      logic signed [63:0] seed_value;
      logic signed [63:0] low_bound;
      logic signed [63:0] high_bound;
   } lcgrs_req_type;

   typedef struct packed {
      logic signed [63:0] value;
      logic [31:0]        state_now;
   } lcgrs_rsp_type;

endpackage

>>> design/lcgrs_divider.sv
// lcgrs_divider: restoring radix-2 remainder unit, one bit per cycle
// 32-bit dividend and divisor, remainder only
// no package dependencies
module lcgrs_divider (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [31:0] dividend,
   input  logic [31:0] divisor,
   output logic        done,
   output logic [31:0] remainder
);

   logic        active_ff;
   logic        done_ff;
   logic [4:0]  cnt_ff;
   logic [31:0] rem_ff;
   logic [31:0] dvd_ff;
   logic [31:0] dsr_ff;
   logic [32:0] trial;
   logic [32:0] trial_diff;
   logic [31:0] rem_in;

   always_comb begin
      trial      = {rem_ff, dvd_ff[31]};
      trial_diff = trial - {1'b0, dsr_ff};
      if (!trial_diff[32]) begin
         rem_in = trial_diff[31:0];
      end else begin
         rem_in = trial[31:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         done_ff   <= 1'b0;
         cnt_ff    <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            active_ff <= 1'b1;
            cnt_ff    <= '0;
         end else if (active_ff) begin
            cnt_ff <= cnt_ff + 5'd1;
            if (cnt_ff == 5'd31) begin
               active_ff <= 1'b0;
               done_ff   <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff <= '0;
         dvd_ff <= dividend;
         dsr_ff <= divisor;
      end else if (active_ff) begin
         rem_ff <= rem_in;
         dvd_ff <= {dvd_ff[30:0], 1'b0};
      end
   end

   assign done      = done_ff;
   assign remainder = rem_ff;

   // partial remainder stays reduced while iterating
   a_rem_reduced: assert property (@(posedge clock) disable iff (reset)
      active_ff |-> rem_ff < dsr_ff)
      else $error("partial remainder not below divisor");

   a_no_restart: assert property (@(posedge clock) disable iff (reset)
      start |-> !active_ff)
      else $error("divider restarted while busy");

   a_done_ends: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> !active_ff && $past(active_ff))
      else $error("done without a finishing iteration");

endmodule

>>> design/lcg_ranged_random_source.sv
// 32-bit linear congruential generator (multiplier 1664525, increment
// 1013904223) with raw draw, signed inclusive ranged draw, load and peek.
// Raw draw, load, peek and a ranged draw with an inverted range pass through
// the prep, eval and done states; a ranged draw with a full-width range adds a
// sum state after eval; an ordinary ranged draw waits in the divide state for
// the 32-step restoring remainder unit that reduces the new state by the range,
// then sums. Each result is registered out of the done state once the output
// register is free, and the next item is taken after that.
// One item is in work at a time; a finished result may wait in the output
// register while the next item is taken. The state is 0 after reset.
module lcg_ranged_random_source
   import lcgrs_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   input  lcgrs_req_type req_item,
   output logic          rsp_valid,
   input  logic          rsp_ready,
   output lcgrs_rsp_type rsp_item
);

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_PREP = 3'd1;
   localparam logic [2:0] S_EVAL = 3'd2;
   localparam logic [2:0] S_DIV  = 3'd3;
   localparam logic [2:0] S_SUM  = 3'd4;
   localparam logic [2:0] S_DONE = 3'd5;

   logic [2:0]          fsm_ff;
   logic [2:0]          fsm_in;
   logic [31:0]         lcg_ff;
   logic [31:0]         lcg_in;
   logic [31:0]         lcg_next;
   lcgrs_req_type       req_ff;
   logic [63:0]         diff_ff;
   logic                inv_ff;
   logic                inv_now;
   logic                wide;
   logic [31:0]         rem_ff;
   logic signed [63:0]  value_ff;
   logic                rsp_valid_ff;
   lcgrs_rsp_type       rsp_ff;
   logic                out_free;
   logic                div_start;
   logic                div_done;
   logic [31:0]         div_rem;

   assign lcg_next  = lcg_ff * LCG_MUL + LCG_INC;
   assign inv_now   = req_ff.low_bound > req_ff.high_bound;
   assign wide      = (diff_ff[63:32] != 32'd0) || (diff_ff[31:0] == 32'hFFFF_FFFF);
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign div_start = (fsm_ff == S_EVAL) && (req_ff.cmd == CMD_RANGED) && !inv_ff && !wide;

   lcgrs_divider u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (lcg_ff),
      .divisor   (diff_ff[31:0] + 32'd1),
      .done      (div_done),
      .remainder (div_rem)
   );

   always_comb begin
      fsm_in = fsm_ff;
      unique case (fsm_ff)
         S_IDLE: begin
            if (req_valid) begin
               fsm_in = S_PREP;
            end
         end
         S_PREP: fsm_in = S_EVAL;
         S_EVAL: begin
            if (req_ff.cmd == CMD_RANGED && !inv_ff) begin
               fsm_in = wide ? S_SUM : S_DIV;
            end else begin
               fsm_in = S_DONE;
            end
         end
         S_DIV: begin
            if (div_done) begin
               fsm_in = S_SUM;
            end
         end
         S_SUM: fsm_in = S_DONE;
         S_DONE: begin
            if (out_free) begin
               fsm_in = S_IDLE;
            end
         end
         default: fsm_in = S_IDLE;
      endcase
   end

   always_comb begin
      lcg_in = lcg_ff;
      if (fsm_ff == S_PREP) begin
         case (req_ff.cmd)
            CMD_RAW:    lcg_in = lcg_next;
            CMD_RANGED: lcg_in = inv_now ? lcg_ff : lcg_next;
            CMD_LOAD:   lcg_in = req_ff.seed_value[31:0];
            default:    lcg_in = lcg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fsm_ff       <= S_IDLE;
         lcg_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         fsm_ff <= fsm_in;
         lcg_ff <= lcg_in;
         if (fsm_ff == S_DONE && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // operand capture and datapath registers
   always_ff @(posedge clock) begin
      if (fsm_ff == S_IDLE && req_valid) begin
         req_ff <= req_item;
      end
      if (fsm_ff == S_PREP) begin
         diff_ff <= req_ff.high_bound - req_ff.low_bound;
         inv_ff  <= inv_now;
      end
      if (fsm_ff == S_EVAL) begin
         rem_ff <= lcg_ff;
         if (req_ff.cmd == CMD_RANGED && inv_ff) begin
            value_ff <= req_ff.low_bound;
         end else begin
            value_ff <= $signed({32'd0, lcg_ff});
         end
      end
      if (fsm_ff == S_DIV && div_done) begin
         rem_ff <= div_rem;
      end
      if (fsm_ff == S_SUM) begin
         value_ff <= req_ff.low_bound + $signed({32'd0, rem_ff});
      end
      if (fsm_ff == S_DONE && out_free) begin
         rsp_ff.value     <= value_ff;
         rsp_ff.state_now <= lcg_ff;
      end
   end

   assign req_ready = (fsm_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

   a_div_only_waited: assert property (@(posedge clock) disable iff (reset)
      div_done |-> fsm_ff == S_DIV)
      else $error("remainder finished outside the divide step");

   a_result_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(fsm_ff) == S_DONE)
      else $error("result raised outside the done step");

   a_inverted_holds: assert property (@(posedge clock) disable iff (reset)
      (fsm_ff == S_PREP && req_ff.cmd == CMD_RANGED && inv_now) |=> $stable(lcg_ff))
      else $error("inverted range advanced the state");

   a_peek_holds: assert property (@(posedge clock) disable iff (reset)
      (fsm_ff == S_PREP && req_ff.cmd == CMD_PEEK) |=> $stable(lcg_ff))
      else $error("peek changed the state");

endmodule

>>> sim/tb.sv
// testbench for lcg_ranged_random_source: directed and random command items,
// checked against an in-bench generator model; depends on lcgrs_pkg and the
// design top level
`timescale 1ns / 100ps

module tb;
   import lcgrs_pkg::*;

   localparam int WATCHDOG_LIMIT = 4000;
   localparam int RANDOM_ITEMS   = 1750;
   localparam int DRAIN_CYCLES   = 60;

   logic          clock = 1'b0;
   logic          reset = 1'b1;
   logic          req_valid = 1'b0;
   logic          req_ready;
   lcgrs_req_type req_item = '0;
   logic          rsp_valid;
   logic          rsp_ready = 1'b0;
   lcgrs_rsp_type rsp_item;

   lcgrs_req_type pending_items[$];
   lcgrs_rsp_type expected_draws[$];
   logic [31:0]   gen_state = 32'd0;
   int            total_items = 0;
   int            accepted_reqs = 0;
   int            accepted_rsps = 0;
   int            errors = 0;
   int            drv_gap = 0;
   int            mon_stall = 0;
   bit            drv_burst = 1'b0;
   bit            mon_burst = 1'b0;
   int            idle_cycles = 0;

   lcg_ranged_random_source dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_item  (rsp_item)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   function automatic logic [31:0] advance_generator(logic [31:0] s);
      logic [31:0] nxt;
      nxt = LCG_MUL * s + LCG_INC;
      return nxt;
   endfunction

   // updates gen_state as the block does for one accepted item
   function automatic lcgrs_rsp_type predict_draw(lcgrs_req_type it);
      lcgrs_rsp_type r;
      logic [63:0]   diff;
      logic [63:0]   rem;
      r = '0;
      case (it.cmd)
         CMD_RAW: begin
            gen_state = advance_generator(gen_state);
            r.value   = {32'd0, gen_state};
         end
         CMD_RANGED: begin
            if ($signed(it.low_bound) > $signed(it.high_bound)) begin
               r.value = it.low_bound;
            end else begin
               gen_state = advance_generator(gen_state);
               diff      = it.high_bound - it.low_bound;
               if (diff >= 64'h0000_0000_FFFF_FFFF) begin
                  rem = {32'd0, gen_state};
               end else begin
                  rem = {32'd0, gen_state} % (diff + 64'd1);
               end
               r.value = it.low_bound + rem;
            end
         end
         CMD_LOAD: begin
            gen_state = it.seed_value[31:0];
            r.value   = {32'd0, gen_state};
         end
         default: begin
            r.value = {32'd0, gen_state};
         end
      endcase
      r.state_now = gen_state;
      return r;
   endfunction

   task automatic push_item(logic [1:0] cmd, logic [63:0] seed, logic [63:0] lo,
                            logic [63:0] hi);
      lcgrs_req_type it;
      it.cmd        = cmd;
      it.seed_value = seed;
      it.low_bound  = lo;
      it.high_bound = hi;
      pending_items.push_back(it);
      total_items++;
   endtask

   task automatic push_random_ranged();
      logic [63:0] lo;
      logic [63:0] hi;
      logic [63:0] d;
      lo = rand64();
      d  = 64'd0;
      case ($urandom_range(0, 7))
         0: d = {32'd0, $urandom_range(0, 15)};
         1: d = {32'd0, $urandom_range(0, 65535)};
         2: d = {32'd0, $urandom};
         3: d = 64'h0000_0000_FFFF_FFFD + {32'd0, $urandom_range(0, 3)};
         4: d = (64'd1 << $urandom_range(0, 63)) - 64'd1;
         5: d = rand64() - lo;
         6: begin
            lo = (64'd1 << 63) + {32'd0, $urandom_range(0, 5)};
            d  = {32'd0, $urandom};
         end
         default: d = -(64'd1 + {32'd0, $urandom_range(0, 100)});
      endcase
      hi = lo + d;
      push_item(CMD_RANGED, rand64(), lo, hi);
   endtask

   // stimulus and end of run
   initial begin
      logic [63:0] smin;
      logic [63:0] smax;
      smin = 64'h8000_0000_0000_0000;
      smax = 64'h7FFF_FFFF_FFFF_FFFF;

      push_item(CMD_PEEK,   rand64(), rand64(), rand64());
      push_item(CMD_RAW,    rand64(), rand64(), rand64());
      push_item(CMD_RAW,    64'd0, 64'd0, 64'd0);
      push_item(CMD_LOAD,   64'hDEAD_BEEF_1234_5678, rand64(), rand64());
      push_item(CMD_PEEK,   64'd0, 64'd0, 64'd0);
      push_item(CMD_LOAD,   64'hFFFF_FFFF_FFFF_FFFF, 64'd0, 64'd0);
      push_item(CMD_RAW,    rand64(), rand64(), rand64());
      push_item(CMD_LOAD,   64'hFFFF_FFFF_0000_0000, 64'd0, 64'd0);
      push_item(CMD_RANGED, 64'd0, 64'd0, 64'd0);
      push_item(CMD_RANGED, rand64(), smin, smin);
      push_item(CMD_RANGED, rand64(), smax, smax);
      push_item(CMD_RANGED, rand64(), smin, smax);
      push_item(CMD_RANGED, rand64(), 64'd0, 64'h0000_0000_FFFF_FFFE);
      push_item(CMD_RANGED, rand64(), 64'd0, 64'h0000_0000_FFFF_FFFF);
      push_item(CMD_RANGED, rand64(), 64'd0, 64'h0000_0001_0000_0000);
      push_item(CMD_RANGED, rand64(), -64'sd5, 64'sd5);
      push_item(CMD_RANGED, rand64(), 64'sd5, -64'sd5);
      push_item(CMD_RANGED, rand64(), smax, smin);
      push_item(CMD_RANGED, rand64(), 64'd1, 64'd0);
      push_item(CMD_RANGED, rand64(), smax - 64'd10, smax);
      push_item(CMD_RANGED, rand64(), smin, smin + 64'd6);
      push_item(CMD_RANGED, rand64(), -64'sd1, -64'sd1);
      push_item(CMD_PEEK,   rand64(), rand64(), rand64());
      push_item(CMD_RAW,    rand64(), rand64(), rand64());

      repeat (RANDOM_ITEMS) begin
         case ($urandom_range(0, 19))
            0, 1, 2, 3, 4:       push_item(CMD_RAW, rand64(), rand64(), rand64());
            5, 6, 7:             push_item(CMD_LOAD, rand64(), rand64(), rand64());
            8, 9, 10:            push_item(CMD_PEEK, rand64(), rand64(), rand64());
            default:             push_random_ranged();
         endcase
      end

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      while (accepted_reqs < total_items) @(posedge clock);
      while (expected_draws.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (errors == 0 && expected_draws.size() == 0 && accepted_rsps == total_items) begin
         $display("PASS lcg_ranged_random_source");
      end else begin
         $display("FAIL lcg_ranged_random_source");
      end
      $finish;
   end

   // request driver
   always @(posedge clock) begin : req_driver
      bit            took;
      bit            next_valid;
      lcgrs_req_type next_item;
      if (reset) begin
         req_valid <= 1'b0;
         drv_gap   = 0;
      end else begin
         took       = 1'b0;
         next_valid = req_valid;
         if (req_valid && req_ready) begin
            expected_draws.push_back(predict_draw(req_item));
            accepted_reqs++;
            took = 1'b1;
            if (accepted_reqs % 128 == 0) begin
               drv_burst = ($urandom_range(0, 2) == 0);
            end
            drv_gap = drv_burst ? 0 : $urandom_range(0, 18);
         end
         if (!req_valid || took) begin
            if (drv_gap > 0) begin
               drv_gap--;
               next_valid = 1'b0;
            end else if (pending_items.size() > 0) begin
               next_item  = pending_items.pop_front();
               req_item  <= next_item;
               next_valid = 1'b1;
            end else begin
               next_valid = 1'b0;
            end
         end
         req_valid <= next_valid;
      end
   end

   // result monitor and checker
   always @(posedge clock) begin : rsp_monitor
      lcgrs_rsp_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
         mon_stall = $urandom_range(0, 18);
      end else begin
         if (rsp_valid && rsp_ready) begin
            accepted_rsps++;
            if (expected_draws.size() == 0) begin
               $display("%0t: unexpected item, value %h state %h", $time,
                        rsp_item.value, rsp_item.state_now);
               errors++;
            end else begin
               want = expected_draws.pop_front();
               if (rsp_item.value !== want.value) begin
                  $display("%0t: value mismatch, expected %h, actual %h", $time,
                           want.value, rsp_item.value);
                  errors++;
               end
               if (rsp_item.state_now !== want.state_now) begin
                  $display("%0t: state_now mismatch, expected %h, actual %h", $time,
                           want.state_now, rsp_item.state_now);
                  errors++;
               end
            end
            if (accepted_rsps % 128 == 0) begin
               mon_burst = ($urandom_range(0, 2) == 0);
            end
            mon_stall = mon_burst ? 0 : $urandom_range(0, 18);
         end
         if (mon_stall > 0) begin
            mon_stall--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // watchdog on cycles with no item moving on either side
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("FAIL lcg_ranged_random_source");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

endmodule

>>> sim.f
design/lcgrs_pkg.sv
design/lcgrs_divider.sv
design/lcg_ranged_random_source.sv
sim/tb.sv
